### rtl/ctc_greedy_text_decoder_assert.svh
// ----------------------------------------------------------------------------
// ctc_greedy_text_decoder_assert
// Assertion macros for the CTC greedy text decoder.
// ----------------------------------------------------------------------------
`ifndef CTC_GREEDY_TEXT_DECODER_ASSERT_SVH
`define CTC_GREEDY_TEXT_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define CTC_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("ctc assertion failed");
`define CTC_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("ctc assertion failed");
`else
`define CTC_ASSERT_IMPL(label, clk, rst_n, a, c)
`define CTC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the CTC greedy text decoder.
// ----------------------------------------------------------------------------
package ctc_pkg;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] THRESH_RESET = 16'd58982;

	typedef struct packed {
		logic signed [15:0] logit_value;
		logic               row_end;
		logic               sequence_end;
	} in_item_t;

	typedef struct packed {
		logic        char_valid;
		logic [6:0]  char_code;
		logic [15:0] char_prob;
		logic        done_res;
		logic [15:0] mean_confidence;
		logic        text_empty;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

	function automatic logic [16:0] pow2_tab(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
			5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
			5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
			5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
			5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
			5'd15: v = 17'd34219; default: v = 17'd32768;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] class_code(input logic [6:0] k);
		logic [6:0] c;
		if (k == 7'd0 || k > 7'd96) c = 7'd0;
		else if (k <= 7'd10) c = 7'd47 + k;
		else if (k == 7'd44) c = 7'd32;
		else if (k >= 7'd45 && k <= 7'd70) c = k + 7'd20;
		else if (k >= 7'd71) c = k + 7'd26;
		else c = 7'd0;
		return c;
	endfunction
endpackage

### rtl/ctc_stream_if.sv
// ----------------------------------------------------------------------------
// ctc_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface ctc_stream_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
	modport monitor(input valid, input data, input ready);
endinterface

### rtl/ctc_divider.sv
// ----------------------------------------------------------------------------
// ctc_divider
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
// ----------------------------------------------------------------------------
module ctc_divider
	import ctc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [31:0] divisor,
	output div_ctl_t    ctl,
	output logic [32:0] quotient
);
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[32]} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
	assign quotient = quo_q;
endmodule

### rtl/ctc_greedy_text_decoder.sv
// Steps: a logit that does not end its row goes through accept, compare, scale, exp and
// update; the first logit of a row and logits past the class limit stop after compare.
// A row end adds the reciprocal, and a sequence end the mean after it; both run one
// quotient bit per cycle through the shared divider. A row end also waits in its output
// step while an earlier result beat has not been taken. A new logit waits for idle.
// Reset: arst_n clears control and row/sequence state, not item_q or the divider's data.
// ----------------------------------------------------------------------------
// ctc_greedy_text_decoder
// Streaming CTC greedy decoder with online softmax confidence.
// ----------------------------------------------------------------------------
`include "ctc_greedy_text_decoder_assert.svh"
module ctc_greedy_text_decoder
	import ctc_pkg::*;
#(
	parameter int MAX_CLASSES = 128,
	parameter int MAX_ROWS = 256
) (
	input  logic clk,
	input  logic arst_n,
	ctc_stream_if.sink   in_ch,
	ctc_stream_if.sink   cfg,
	ctc_stream_if.source out_ch
);
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL = 4'd1;
	localparam logic [3:0] ST_EXP = 4'd2;
	localparam logic [3:0] ST_UPD = 4'd3;
	localparam logic [3:0] ST_RESC = 4'd4;
	localparam logic [3:0] ST_PDIV = 4'd5;
	localparam logic [3:0] ST_PWAIT = 4'd6;
	localparam logic [3:0] ST_MDIV = 4'd7;
	localparam logic [3:0] ST_MWAIT = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [3:0]  state_q;
	logic [15:0] thresh_q;
	in_item_t    item_q;

	// Row state.
	logic signed [15:0] row_max_q;
	logic [6:0]  row_argmax_q;
	logic [CW-1:0] class_counter_q;
	logic [31:0] exp_sum_q;
	logic        up_q;
	logic [15:0] diff_q;
	logic [32:0] t_q;
	logic [16:0] e_q;

	// Sequence state.
	logic [7:0]  prev_class_q;
	logic [24:0] emit_sum_q;
	logic [8:0]  emit_cnt_q;
	logic [24:0] row_sum_q;
	logic [8:0]  row_cnt_q;
	logic [15:0] p_q;
	out_item_t   res_q;
	logic        res_valid_q;

	// Shared divider.
	logic        div_start;
	logic [32:0] div_a;
	logic [31:0] div_b;
	div_ctl_t    div_ctl;
	logic [32:0] div_q;

	ctc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .ctl(div_ctl), .quotient(div_q)
	);

	// The result register parts the two sides: new logits are taken while a result
	// beat waits, and only the output step of a row holds until it has gone.
	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = res_valid_q;
	assign out_ch.data = res_q;

	logic        acc;
	logic signed [16:0] xd;
	logic [16:0] ta, tb, interp;
	logic [28:0] wprod;
	logic [4:0]  fidx;
	logic [11:0] fw;
	logic [48:0] resc;
	logic [6:0]  code;
	logic        emit;
	logic        full_rows;

	assign acc = in_ch.valid && in_ch.ready;
	assign xd = {item_q.logit_value[15], item_q.logit_value} - {row_max_q[15], row_max_q};
	assign fidx = {1'b0, t_q[23:20]};
	assign fw = t_q[19:8];
	assign ta = pow2_tab(fidx);
	assign tb = pow2_tab(fidx + 5'd1);
	assign wprod = (ta - tb) * {5'b0, fw};
	assign interp = ta - wprod[28:12];
	assign resc = exp_sum_q * e_q;
	assign code = class_code(row_argmax_q);
	assign emit = (row_argmax_q != 7'd0) && ({1'b0, row_argmax_q} != prev_class_q)
		&& (code != 7'd0) && (p_q > thresh_q);
	assign full_rows = row_cnt_q >= RW'(MAX_ROWS);

	always_comb begin
		div_start = 1'b0;
		div_a = 33'h1_0000_0000;
		div_b = exp_sum_q;
		if (state_q == ST_PDIV) begin
			div_start = exp_sum_q != 32'd0;
		end else if (state_q == ST_MDIV) begin
			div_start = 1'b1;
			if (emit_cnt_q != 9'd0) begin
				div_a = {8'd0, emit_sum_q};
				div_b = {23'd0, emit_cnt_q};
			end else begin
				div_a = {8'd0, row_sum_q};
				div_b = {23'd0, row_cnt_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			thresh_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) item_q <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			row_max_q <= '0;
			row_argmax_q <= '0;
			class_counter_q <= '0;
			exp_sum_q <= '0;
			prev_class_q <= 8'd255;
			emit_sum_q <= '0;
			emit_cnt_q <= '0;
			row_sum_q <= '0;
			row_cnt_q <= '0;
			up_q <= 1'b0;
			diff_q <= '0;
			t_q <= '0;
			e_q <= '0;
			p_q <= '0;
			res_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) state_q <= ST_MUL;
				end
				ST_MUL: begin
					// Classes beyond the limit only contribute their marks.
					if (class_counter_q >= CW'(MAX_CLASSES)) begin
						state_q <= item_q.row_end ? ST_PDIV : ST_IDLE;
					end else if (class_counter_q == '0) begin
						row_max_q <= item_q.logit_value;
						row_argmax_q <= '0;
						exp_sum_q <= 32'(ONE_Q16);
						class_counter_q <= class_counter_q + CW'(1);
						state_q <= item_q.row_end ? ST_PDIV : ST_IDLE;
					end else begin
						up_q <= !xd[16] && xd != 17'd0;
						diff_q <= (!xd[16] && xd != 17'd0) ? xd[15:0] : 16'(-xd);
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					t_q <= {17'd0, diff_q} * {16'd0, LOG2E_Q16};
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					e_q <= (t_q[32:24] >= 9'd17) ? 17'd0 : (interp >> t_q[28:24]);
					state_q <= ST_RESC;
				end
				ST_RESC: begin
					if (up_q) begin
						exp_sum_q <= resc[47:16] + 32'(ONE_Q16);
						row_max_q <= item_q.logit_value;
						row_argmax_q <= 7'(class_counter_q);
					end else begin
						exp_sum_q <= exp_sum_q + {15'd0, e_q};
					end
					class_counter_q <= class_counter_q + CW'(1);
					state_q <= item_q.row_end ? ST_PDIV : ST_IDLE;
				end
				ST_PDIV: begin
					if (exp_sum_q == 32'd0) begin
						p_q <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PWAIT;
					end
				end
				ST_PWAIT: begin
					if (div_ctl.done) begin
						p_q <= (div_q > 33'd65535) ? 16'hFFFF : div_q[15:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// The result register is reused, so the row waits here until the
					// previous beat has been taken.
					if (!res_valid_q) begin
						res_q.char_valid <= emit;
						res_q.char_code <= emit ? code : 7'd0;
						res_q.char_prob <= emit ? p_q : 16'd0;
						res_q.done_res <= 1'b0;
						res_q.mean_confidence <= '0;
						res_q.text_empty <= 1'b0;
						prev_class_q <= {1'b0, row_argmax_q};
						if (!full_rows) begin
							row_sum_q <= row_sum_q + {9'd0, p_q};
							row_cnt_q <= row_cnt_q + 9'd1;
							if (emit) begin
								emit_sum_q <= emit_sum_q + {9'd0, p_q};
								emit_cnt_q <= emit_cnt_q + 9'd1;
							end
						end
						row_max_q <= '0;
						row_argmax_q <= '0;
						class_counter_q <= '0;
						exp_sum_q <= '0;
						if (item_q.sequence_end) begin
							state_q <= ST_MDIV;
						end else begin
							res_valid_q <= emit;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MDIV: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (div_ctl.done) begin
						res_q.done_res <= 1'b1;
						res_q.mean_confidence <= (row_cnt_q == 9'd0) ? 16'd0 : div_q[15:0];
						res_q.text_empty <= emit_cnt_q == 9'd0;
						res_valid_q <= 1'b1;
						prev_class_q <= 8'd255;
						emit_sum_q <= '0;
						emit_cnt_q <= '0;
						row_sum_q <= '0;
						row_cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The divider is only started from the two launch states.
	`CTC_ASSERT_IMPL(a_div_start, clk, arst_n, div_ctl.start,
		state_q == ST_PDIV || state_q == ST_MDIV)
	// A waiting result beat stays unchanged until it is taken.
	`CTC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid_q && !out_ch.ready,
		res_valid_q && $stable(res_q))
	// A closing result always follows a mean division.
	`CTC_ASSERT_NEXT(a_done_after_wait, clk, arst_n,
		state_q == ST_MWAIT && div_ctl.done, res_valid_q && res_q.done_res)
endmodule

### verif/ctc_decoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctc_decoder_checker
// Watches the logit, threshold and result channels of the CTC decoder, keeps
// its own row and sequence state, and compares each result beat in order.
// ----------------------------------------------------------------------------
module ctc_decoder_checker
	import ctc_pkg::*;
#(
	parameter int MAX_CLASSES = 128,
	parameter int MAX_ROWS = 256
) (
	input  logic clk,
	input  logic arst_n,
	ctc_stream_if.monitor in_ch,
	ctc_stream_if.monitor cfg,
	ctc_stream_if.monitor out_ch,
	output int   fail_count,
	output int   pending,
	output int   chars_seen,
	output int   seqs_seen
);
	localparam int unsigned POW2_Q16 [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
		50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
	localparam logic [7:0] NONE_YET = 8'd255;

	logic signed [15:0] top_logit;
	logic [6:0]         top_class;
	int                 class_pos;
	logic [31:0]        denom;
	logic [7:0]         last_class;
	logic [24:0]        char_prob_acc;
	logic [8:0]         char_count;
	logic [24:0]        row_prob_acc;
	logic [8:0]         row_total;
	logic [15:0]        threshold;
	out_item_t          expected_results[$];

	// exp(-d) for a non-negative Q8.8 distance, as a Q1.16 value.
	function automatic logic [16:0] neg_exp(input logic [15:0] d);
		logic [63:0] t;
		logic [15:0] f;
		logic [31:0] v;
		int unsigned i, n;
		t = 64'(d) * 64'd94548;
		n = int'(t >> 24);
		if (n >= 17) return 17'd0;
		f = t[23:8];
		i = f[15:12];
		v = POW2_Q16[i] - (((POW2_Q16[i] - POW2_Q16[i + 1]) * f[11:0]) >> 12);
		return 17'(v >> n);
	endfunction

	function automatic logic [6:0] ascii_of(input logic [6:0] k);
		int i;
		if (k == 0 || k > 96) return 7'd0;
		i = k - 1;
		if (i < 10) return 7'(48 + i);
		if (i == 43) return 7'd32;
		if (i >= 44 && i <= 69) return 7'(65 + i - 44);
		if (i >= 70) return 7'(97 + i - 70);
		return 7'd0;
	endfunction

	task automatic report(input out_item_t want, input out_item_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t result mismatch: expected valid=%0d code=%0d prob=%0d",
				$realtime, want.char_valid, want.char_code, want.char_prob,
				" done=%0d mean=%0d empty=%0d,", want.done_res,
				want.mean_confidence, want.text_empty,
				" got valid=%0d code=%0d prob=%0d", got.char_valid, got.char_code,
				got.char_prob, " done=%0d mean=%0d empty=%0d", got.done_res,
				got.mean_confidence, got.text_empty);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [16:0] x;
		logic [31:0] p;
		logic [6:0]  code;
		logic        emit;
		out_item_t   r, want;
		if (!arst_n) begin
			top_logit = '0; top_class = '0; class_pos = 0; denom = '0;
			last_class = NONE_YET; char_prob_acc = '0; char_count = '0;
			row_prob_acc = '0; row_total = '0; threshold = THRESH_RESET;
			expected_results.delete();
			fail_count = 0; chars_seen = 0; seqs_seen = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				threshold = cfg.data;
			if (out_ch.valid && out_ch.ready) begin
				r = out_ch.data;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected result beat: valid=%0d code=%0d done=%0d",
							$realtime, r.char_valid, r.char_code, r.done_res);
				end else begin
					want = expected_results.pop_front();
					if (r.char_valid !== want.char_valid || r.char_code !== want.char_code ||
							r.char_prob !== want.char_prob || r.done_res !== want.done_res ||
							r.mean_confidence !== want.mean_confidence ||
							r.text_empty !== want.text_empty)
						report(want, r);
				end
				if (r.char_valid === 1'b1) chars_seen++;
				if (r.done_res === 1'b1) seqs_seen++;
			end
			if (in_ch.valid && in_ch.ready) begin
				x = 17'(in_ch.data.logit_value);
				if (class_pos < MAX_CLASSES) begin
					if (class_pos == 0) begin
						top_logit = x[15:0]; top_class = '0; denom = 32'd65536;
					end else if (x > 17'(top_logit)) begin
						denom = 32'((64'(denom) * neg_exp(16'(x - top_logit))) >> 16) + 32'd65536;
						top_logit = x[15:0];
						top_class = 7'(class_pos);
					end else begin
						denom += neg_exp(16'(top_logit - x));
					end
					class_pos++;
				end
				if (in_ch.data.row_end) begin
					p = (denom != 0) ? 32'(64'h1_0000_0000 / denom) : 32'd0;
					if (p > 32'd65535) p = 32'd65535;
					code = ascii_of(top_class);
					emit = top_class != 0 && {1'b0, top_class} != last_class && code != 0 &&
						p > threshold;
					last_class = {1'b0, top_class};
					if (row_total < MAX_ROWS) begin
						row_prob_acc += p; row_total++;
						if (emit) begin
							char_prob_acc += p; char_count++;
						end
					end
					top_logit = '0; top_class = '0; class_pos = 0; denom = '0;
					r = '0;
					if (emit) begin
						r.char_valid = 1'b1; r.char_code = code; r.char_prob = p[15:0];
					end
					if (in_ch.data.sequence_end) begin
						r.done_res = 1'b1;
						if (char_count != 0) r.mean_confidence = 16'(char_prob_acc / char_count);
						else if (row_total != 0) r.mean_confidence = 16'(row_prob_acc / row_total);
						r.text_empty = (char_count == 0);
						last_class = NONE_YET; char_prob_acc = '0; char_count = '0;
						row_prob_acc = '0; row_total = '0;
					end
					if (emit || in_ch.data.sequence_end)
						expected_results.insert(expected_results.size(), r);
				end
			end
		end
		pending = expected_results.size();
	end
endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives logit rows and threshold writes into the CTC greedy decoder with
// random gaps and result stalls; the checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import ctc_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count, pending, chars_seen, seqs_seen;
	int   logits_sent;
	int   prev_winner;
	bit   no_gaps;

	ctc_stream_if #(.T(in_item_t))    in_ch(clk);
	ctc_stream_if #(.T(logic [15:0])) cfg(clk);
	ctc_stream_if #(.T(out_item_t))   out_ch(clk);

	ctc_greedy_text_decoder DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
	);

	ctc_decoder_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending),
		.chars_seen(chars_seen), .seqs_seen(seqs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time, far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("timeout with %0d results still expected", pending);
		$display("tb_top NOT OK");
		$finish;
	end

	// Most gaps are zero or short; a few are long. While no_gaps is set the
	// sender runs back to back so the block also sees full-rate stretches.
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The result side stalls with the same kind of spread, drawn apart from the sender but also zero while no_gaps is set.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	// One logit beat. Valid is dropped only when a gap follows, so it is never
	// lowered and raised again within one time step.
	task automatic send_logit(input logic signed [15:0] v, input bit last, input bit seq_last);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.data <= '{logit_value: v, row_end: last, sequence_end: seq_last};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		logits_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (logits_sent % 97 == 0) no_gaps = ($urandom_range(0, 3) == 0);
	endtask

	// Threshold writes happen only with nothing in flight: every expected result
	// has come back and the block has had time to finish any row that emits nothing.
	task automatic write_threshold(input logic [15:0] thr);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= thr;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return 16'(v);
	endfunction

	// One row of class logits. A peaked row has one clear winner far above the
	// rest, which is what lets characters pass a high threshold; the winner is
	// sometimes the previous row's, sometimes blank or outside the alphabet, and
	// sometimes tied with another class. Other rows are plain noise. Rows longer
	// than the class limit check that extra logits are ignored.
	task automatic send_row(input int ncls, input bit seq_last);
		int  winner, tie_at, base, r;
		bit  peaked;
		logic signed [15:0] v;
		peaked = ($urandom_range(0, 99) < 70);
		r = $urandom_range(0, 99);
		if (r < 15 && prev_winner < ncls) winner = prev_winner;
		else if (r < 22) winner = 0;
		else winner = $urandom_range(0, ncls - 1);
		if (winner > 127) winner = $urandom_range(0, 127);
		tie_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, ncls - 1) : -1;
		base = $urandom_range(0, 65535) - 32768;
		prev_winner = winner;
		for (int c = 0; c < ncls; c++) begin
			if (!peaked) v = 16'($urandom);
			else if (c == winner || c == tie_at) v = clamp16(base);
			else v = clamp16(base - int'($urandom_range(16'h0200, 16'h3000)));
			send_logit(v, c == ncls - 1,
				(c == ncls - 1) ? seq_last : ($urandom_range(0, 29) == 0));
		end
	endtask

	function automatic int pick_classes();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 12);
		if (r < 92) return $urandom_range(13, 40);
		if (r < 98) return 128;
		return $urandom_range(129, 133);
	endfunction

	task automatic send_sequences(input int item_budget);
		int start, rows;
		start = logits_sent;
		while (logits_sent - start < item_budget) begin
			rows = $urandom_range(1, 8);
			for (int k = 0; k < rows; k++) send_row(pick_classes(), k == rows - 1);
		end
	endtask

	initial begin
		logic [15:0] thr_list[5];
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		logits_sent = 0;
		prev_winner = 0;
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold. Blank winner at the field extremes.
		send_logit(16'sh7FFF, 0, 0);
		send_logit(-16'sh8000, 1, 0);
		// Class 1 ('0') wins by the widest margin, then repeats and is dropped.
		send_logit(-16'sh8000, 0, 0);
		send_logit(16'sh7FFF, 1, 0);
		send_logit(-16'sh8000, 0, 0);
		send_logit(16'sh7FFF, 1, 0);
		// Tie between classes 2 and 3: the lower one wins, at a low probability.
		send_logit(16'sh0000, 0, 0);
		send_logit(16'sh0000, 0, 0);
		send_logit(16'sh0800, 0, 1);
		send_logit(16'sh0800, 1, 0);
		// A sequence-end mark without a row end, then a row ended by sequence end.
		send_logit(-16'sh0400, 0, 1);
		send_logit(16'sh0000, 0, 0);
		send_logit(16'sh2000, 1, 1);
		// A sequence of one noisy row that emits nothing.
		send_logit(16'sh0100, 0, 0);
		send_logit(16'sh0101, 0, 0);
		send_logit(16'sh0100, 1, 1);
		// Mean over more than the row limit: 260 rows of two classes.
		for (int k = 0; k < 260; k++) send_row(2, k == 259);

		send_sequences(200);
		thr_list = '{16'd0, 16'd65535, 16'd32768, 16'($urandom), THRESH_RESET};
		foreach (thr_list[i]) begin
			write_threshold(thr_list[i]);
			send_sequences(190);
		end

		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d logits over 6 threshold settings;", logits_sent,
			" %0d characters and %0d sequence ends checked.", chars_seen, seqs_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, pending);
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
